### rtl/core/aad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aad_pkg;

  localparam int FIT_W  = 32;
  localparam int COEF_W = 32;
  localparam int ITER_W = 24;
  localparam int DRAW_W = 16;
  localparam int ICPT_W = 16;
  localparam int IDX_W  = 2;
  localparam int XMAG_W = 21;
  localparam int DECAY_W = 33;

  // Acceptance modes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_EXP  = 2'd1;
  localparam logic [1:0] MODE_LIN  = 2'd2;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_MODE      = 2'd0;
  localparam logic [IDX_W-1:0] REG_EXP_COEFF = 2'd1;
  localparam logic [IDX_W-1:0] REG_GRADIENT  = 2'd2;
  localparam logic [IDX_W-1:0] REG_INTERCEPT = 2'd3;

  localparam logic [ICPT_W-1:0] INTERCEPT_RESET = 16'd32768;

  // Exponent magnitude cap, 16.0 in Q16.16
  localparam logic [XMAG_W-1:0] EXP_CAP = 21'd1048576;
  // log2(e) in Q2.30
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  // Decay cap, 256.0 in Q.24
  localparam logic [DECAY_W-1:0] DECAY_CAP = 33'h1_0000_0000;

  // 2^(-k/16) in Q.16
  localparam logic [16:0] POW2_TAB [0:16] = '{
    17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
    17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
    17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
  };

  typedef struct packed {
    logic [1:0]        mode;
    logic [COEF_W-1:0] exp_coeff;
    logic [COEF_W-1:0] gradient;
    logic [ICPT_W-1:0] intercept;
  } cfg_t;

  typedef struct packed {
    logic [FIT_W-1:0]  old_fitness;
    logic [FIT_W-1:0]  new_fitness;
    logic [ITER_W-1:0] iteration;
    logic [DRAW_W-1:0] random_draw;
  } sample_t;

  typedef struct packed {
    logic               improve;
    logic [XMAG_W-1:0]  xmag;
    logic [DECAY_W-1:0] decay;
    logic [DRAW_W-1:0]  random_draw;
  } front_t;

  typedef struct packed {
    logic               improve;
    logic [DECAY_W-1:0] decay;
    logic [DRAW_W-1:0]  random_draw;
  } mid_t;

endpackage

`default_nettype wire

### rtl/core/aad_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface aad_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [aad_pkg::FIT_W-1:0] old_fitness;
  logic signed [aad_pkg::FIT_W-1:0] new_fitness;
  logic [aad_pkg::ITER_W-1:0]       iteration;
  logic [aad_pkg::DRAW_W-1:0]       random_draw;

  modport source (output valid, old_fitness, new_fitness, iteration, random_draw,
                  input ready);
  modport sink (input valid, old_fitness, new_fitness, iteration, random_draw,
                output ready);
endinterface

`default_nettype wire

### rtl/core/aad_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface aad_out_if;
  logic valid;
  logic ready;
  logic accept;

  modport source (output valid, accept, input ready);
  modport sink (input valid, accept, output ready);
endinterface

`default_nettype wire

### rtl/core/aad_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface aad_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [aad_pkg::IDX_W-1:0]   index;
  logic [aad_pkg::COEF_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/aad_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Fitness difference, decay products and exponent magnitude: four stages.
module aad_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire aad_pkg::cfg_t    ctrl,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire aad_pkg::sample_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output aad_pkg::front_t       out_data
);

  // Stage 1: difference and the two decay products
  logic                      v1;
  logic                      improve1;
  logic [31:0]               diff1;
  logic signed [56:0]        t1;
  logic signed [56:0]        g1;
  logic [aad_pkg::DRAW_W-1:0] draw1;

  // Stage 2: exponent multiplier magnitude and clamped linear decay
  logic                       v2;
  logic                       improve2;
  logic [31:0]                diff2;
  logic                       tneg2;
  logic [44:0]                m2;
  logic [aad_pkg::DECAY_W-1:0] decay2;
  logic [aad_pkg::DRAW_W-1:0]  draw2;

  // Stage 3: partial products of diff * m
  logic                       v3;
  logic                       improve3;
  logic [31:0]                diff3;
  logic                       tneg3;
  logic [53:0]                ph3;
  logic [54:0]                pl3;
  logic [aad_pkg::DECAY_W-1:0] decay3;
  logic [aad_pkg::DRAW_W-1:0]  draw3;

  // Stage 4: output register
  logic v4;

  logic adv1, adv2, adv3, adv4;

  logic signed [32:0] diff_full;
  logic signed [56:0] t_full;
  logic signed [56:0] g_full;
  logic [56:0]        m_full;
  logic signed [57:0] d_full;
  logic [aad_pkg::DECAY_W-1:0] decay_clamped;
  logic [53:0]        ph;
  logic [54:0]        pl;
  logic               prod_sat;
  logic [44:0]        prod_sum;
  logic [aad_pkg::XMAG_W-1:0] xmag_exp;
  logic [aad_pkg::XMAG_W-1:0] xmag_lin;

  assign adv4 = !v4 || out_ready;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_ready  = adv1;
  assign out_valid = v4;

  assign diff_full = $signed({in_data.old_fitness[31], in_data.old_fitness})
                   - $signed({in_data.new_fitness[31], in_data.new_fitness});
  assign t_full = $signed(ctrl.exp_coeff) * $signed({1'b0, in_data.iteration});
  assign g_full = $signed(ctrl.gradient) * $signed({1'b0, in_data.iteration});

  assign m_full = 57'(-t1);
  assign d_full = $signed({34'd0, ctrl.intercept, 8'd0}) + g1;

  always_comb begin
    if (d_full[57]) begin
      decay_clamped = '0;
    end else if (d_full > $signed({25'd0, aad_pkg::DECAY_CAP})) begin
      decay_clamped = aad_pkg::DECAY_CAP;
    end else begin
      decay_clamped = d_full[32:0];
    end
  end

  assign ph = diff2 * m2[44:23];
  assign pl = diff2 * m2[22:0];

  // Anything at or above 2^44 saturates the exponent at 16.0
  assign prod_sat = (|ph3[53:21]) || (|pl3[54:44]);
  assign prod_sum = {ph3[20:0], 23'd0} + {1'b0, pl3[43:0]};

  always_comb begin
    if (!tneg3) begin
      xmag_exp = '0;
    end else if (prod_sat || prod_sum[44]) begin
      xmag_exp = aad_pkg::EXP_CAP;
    end else begin
      xmag_exp = {1'b0, prod_sum[43:24]};
    end
    if (diff3 > 32'(aad_pkg::EXP_CAP)) begin
      xmag_lin = aad_pkg::EXP_CAP;
    end else begin
      xmag_lin = diff3[20:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      improve1 <= diff_full[32];
      diff1    <= diff_full[31:0];
      t1       <= t_full;
      g1       <= g_full;
      draw1    <= in_data.random_draw;
    end
    if (adv2) begin
      improve2 <= improve1;
      diff2    <= diff1;
      tneg2    <= t1[56];
      // clamp the multiplier so that any nonzero diff still saturates
      m2       <= (|m_full[56:45]) ? '1 : m_full[44:0];
      decay2   <= decay_clamped;
      draw2    <= draw1;
    end
    if (adv3) begin
      improve3 <= improve2;
      diff3    <= diff2;
      tneg3    <= tneg2;
      ph3      <= ph;
      pl3      <= pl;
      decay3   <= decay2;
      draw3    <= draw2;
    end
    if (adv4) begin
      out_data.improve     <= improve3;
      out_data.xmag        <= (ctrl.mode == aad_pkg::MODE_EXP) ? xmag_exp : xmag_lin;
      out_data.decay       <= decay3;
      out_data.random_draw <= draw3;
    end
  end

endmodule

`default_nettype wire

### rtl/core/aad_neg_exp.sv
`timescale 1ns / 1ps
`default_nettype none

// exp(-x) by base-2 conversion and table interpolation: three stages.
module aad_neg_exp #(
  parameter int PROB_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire aad_pkg::front_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output aad_pkg::mid_t        out_data,
  output logic [PROB_BITS:0]   out_exp
);

  logic              v5, v6, v7;
  logic              adv5, adv6, adv7;
  aad_pkg::mid_t     mid5, mid6;
  logic [20:0]       y5;
  logic [16:0]       tk6;
  logic [23:0]       dprod6;
  logic [4:0]        n6;

  logic [51:0]       yprod;
  logic [3:0]        k;
  logic [16:0]       tk;
  logic [16:0]       tk1;
  logic [11:0]       delta;
  logic [23:0]       dprod;
  logic [16:0]       v;
  logic [5:0]        sh;
  logic [PROB_BITS+16:0] scaled;

  assign adv7 = !v7 || out_ready;
  assign adv6 = !v6 || adv7;
  assign adv5 = !v5 || adv6;
  assign in_ready  = adv5;
  assign out_valid = v7;

  assign yprod = in_data.xmag * aad_pkg::LOG2E_Q30;

  assign k     = y5[15:12];
  assign tk    = aad_pkg::POW2_TAB[{1'b0, k}];
  assign tk1   = aad_pkg::POW2_TAB[{1'b0, k} + 5'd1];
  assign delta = 12'(tk - tk1);
  assign dprod = delta * y5[11:0];

  assign v      = tk6 - {5'd0, dprod6[23:12]};
  assign sh     = 6'd16 + {1'b0, n6};
  assign scaled = {v, {PROB_BITS{1'b0}}} >> sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (adv5) v5 <= in_valid;
      if (adv6) v6 <= v5;
      if (adv7) v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      y5   <= yprod[50:30];
      mid5 <= '{improve: in_data.improve, decay: in_data.decay,
                random_draw: in_data.random_draw};
    end
    if (adv6) begin
      tk6    <= tk;
      dprod6 <= dprod;
      n6     <= y5[20:16];
      mid6   <= mid5;
    end
    if (adv7) begin
      out_exp  <= scaled[PROB_BITS:0];
      out_data <= mid6;
    end
  end

endmodule

`default_nettype wire

### rtl/core/aad_decide.sv
`timescale 1ns / 1ps
`default_nettype none

// Linear decay scaling, saturation and the draw compare: two stages.
module aad_decide #(
  parameter int PROB_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [1:0]          mode,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire aad_pkg::mid_t       in_data,
  input  wire logic [PROB_BITS:0]  in_exp,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     accept
);

  localparam logic [PROB_BITS+8:0] ONE_W = {8'd0, 1'b1, {PROB_BITS{1'b0}}};

  logic                       v8, v9;
  logic                       adv8, adv9;
  logic                       improve8;
  logic                       big8;
  logic [PROB_BITS:0]         e8;
  logic [PROB_BITS+32:0]      prod8;
  logic [aad_pkg::DRAW_W-1:0] draw8;

  logic [PROB_BITS+32:0]      prod;
  logic [PROB_BITS+8:0]       pw;
  logic [PROB_BITS:0]         p;
  logic                       below;
  logic                       decide;

  assign adv9 = !v9 || out_ready;
  assign adv8 = !v8 || adv9;
  assign in_ready  = adv8;
  assign out_valid = v9;

  assign prod = in_exp * in_data.decay[31:0];

  always_comb begin
    if (mode == aad_pkg::MODE_EXP) begin
      pw = {8'd0, e8};
    end else if (big8) begin
      // decay of exactly 256.0
      pw = {e8, 8'd0};
    end else begin
      pw = prod8[PROB_BITS+32:24];
    end
    p      = (pw > ONE_W) ? ONE_W[PROB_BITS:0] : pw[PROB_BITS:0];
    below  = {1'b0, draw8, {PROB_BITS{1'b0}}} < {p, 16'd0};
    decide = improve8 ||
             (((mode == aad_pkg::MODE_EXP) || (mode == aad_pkg::MODE_LIN)) && below);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else begin
      if (adv8) v8 <= in_valid;
      if (adv9) v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv8) begin
      improve8 <= in_data.improve;
      big8     <= in_data.decay[32];
      e8       <= in_exp;
      prod8    <= prod;
      draw8    <= in_data.random_draw;
    end
    if (adv9) begin
      accept <= decide;
    end
  end

endmodule

`default_nettype wire

### rtl/core/annealing_acceptance_decision.sv
`timescale 1ns / 1ps
`default_nettype none

// Annealing acceptance decision.
// sample: one transaction per acceptance test (old and new fitness in signed
//   Q16.16, iteration count, uniform draw in Q0.16).
// result: one transaction per test with the accept bit; a strictly better
//   new fitness is always accepted, otherwise the mode register picks the rule.
// cfg: register writes by index (mode, decay coefficient, gradient,
//   intercept); always ready, write only while no test is in flight.
// The sample passes through nine pipeline registers on its way to the
//   result (four in the difference and exponent front, three in the
//   exp(-x) unit, two in the decision stage).
// Throughput: one test per cycle when result.ready is high; every stage has its
//   own valid bit and advances whenever it is empty or the stage after it moves.
// Stall: when result.ready is low the result holds, the stages behind it fill
//   up one by one and sample.ready drops only once all nine are full.
// Reset: all pipeline stages are emptied and the registers return to mode
//   improvements only, zero coefficients and an intercept of one half.
module annealing_acceptance_decision #(
  parameter int PROB_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  aad_in_if.sink    sample,
  aad_out_if.source result,
  aad_cfg_if.sink   cfg
);

  aad_pkg::cfg_t    ctrl;
  aad_pkg::sample_t sample_data;
  aad_pkg::front_t  front_data;
  aad_pkg::mid_t    mid_data;
  logic             front_valid, front_ready;
  logic             mid_valid, mid_ready;
  logic [PROB_BITS:0] mid_exp;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.mode      <= aad_pkg::MODE_NONE;
      ctrl.exp_coeff <= '0;
      ctrl.gradient  <= '0;
      ctrl.intercept <= aad_pkg::INTERCEPT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        aad_pkg::REG_MODE:      ctrl.mode      <= cfg.data[1:0];
        aad_pkg::REG_EXP_COEFF: ctrl.exp_coeff <= cfg.data;
        aad_pkg::REG_GRADIENT:  ctrl.gradient  <= cfg.data;
        aad_pkg::REG_INTERCEPT: ctrl.intercept <= cfg.data[aad_pkg::ICPT_W-1:0];
      endcase
    end
  end

  assign sample_data = '{old_fitness: sample.old_fitness,
                         new_fitness: sample.new_fitness,
                         iteration:   sample.iteration,
                         random_draw: sample.random_draw};

  aad_front u_front (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .in_data   (sample_data),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  aad_neg_exp #(
    .PROB_BITS (PROB_BITS)
  ) u_neg_exp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_data),
    .out_exp   (mid_exp)
  );

  aad_decide #(
    .PROB_BITS (PROB_BITS)
  ) u_decide (
    .clk       (clk),
    .rst       (rst),
    .mode      (ctrl.mode),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_data   (mid_data),
    .in_exp    (mid_exp),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .accept    (result.accept)
  );

endmodule

`default_nettype wire

### test/aad_decision_checker.sv
`timescale 1ns / 1ps

module aad_decision_checker
  import aad_pkg::*;
#(
  parameter int PROB_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  aad_in_if    sample,
  aad_out_if   result,
  aad_cfg_if   cfg,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    sample_t item;
    logic    accept;
  } decision_t;

  localparam bit [63:0] X_CAP     = 64'd1048576;
  localparam bit [63:0] LOG2E_FIX = 64'd1549082005;
  localparam longint    D_CAP     = 64'sd4294967296;
  localparam bit [63:0] P_ONE     = 64'd1 << PROB_BITS;

  // 2^(-k/16) in Q.16
  localparam bit [63:0] EXP2_FRAC [0:16] = '{
    64'd65536, 64'd62757, 64'd60097, 64'd57549, 64'd55109, 64'd52773,
    64'd50535, 64'd48393, 64'd46341, 64'd44376, 64'd42495, 64'd40693,
    64'd38968, 64'd37316, 64'd35734, 64'd34219, 64'd32768
  };

  logic [1:0]         cur_mode;
  logic signed [31:0] cur_coeff;
  logic signed [31:0] cur_grad;
  logic [15:0]        cur_icpt;

  decision_t accept_q[$];
  decision_t head;
  decision_t fresh;

  // exp(-x), x in Q16.16; answer in Q0.PROB_BITS
  function automatic bit [63:0] exp_neg(input bit [63:0] x);
    bit [63:0] xs, y, n, f, k, rem, v;
    xs  = (x > X_CAP) ? X_CAP : x;
    y   = (xs * LOG2E_FIX) >> 30;
    n   = y >> 16;
    f   = y & 64'hFFFF;
    k   = f >> 12;
    rem = f & 64'hFFF;
    v   = EXP2_FRAC[k] - (((EXP2_FRAC[k] - EXP2_FRAC[k + 1]) * rem) >> 12);
    return (v << PROB_BITS) >> (16 + n);
  endfunction

  function automatic logic predict_accept(input sample_t s);
    longint     oldf, newf, t, d;
    bit [63:0]  diff, m, xmag, p;
    bit [127:0] prod;
    oldf = longint'($signed(s.old_fitness));
    newf = longint'($signed(s.new_fitness));
    if (oldf < newf) return 1'b1;
    diff = 64'(oldf - newf);
    case (cur_mode)
      MODE_EXP: begin
        t = longint'(cur_coeff) * longint'(s.iteration);
        if (t >= 0) begin
          xmag = '0;
        end else begin
          m    = 64'(-t);
          prod = (128'(diff) * 128'(m)) >> 24;
          xmag = (prod > 128'(X_CAP)) ? X_CAP : prod[63:0];
        end
        p = exp_neg(xmag);
      end
      MODE_LIN: begin
        d = (longint'(cur_icpt) <<< 8) + longint'(cur_grad) * longint'(s.iteration);
        if (d < 0) d = 0;
        if (d > D_CAP) d = D_CAP;
        xmag = (diff > X_CAP) ? X_CAP : diff;
        p    = (exp_neg(xmag) * 64'(d)) >> 24;
      end
      default: return 1'b0;
    endcase
    if (p > P_ONE) p = P_ONE;
    return ((64'(s.random_draw) << PROB_BITS) < (p << 16));
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      accept_q.delete();
      pending   = 0;
      cur_mode  <= MODE_NONE;
      cur_coeff <= '0;
      cur_grad  <= '0;
      cur_icpt  <= INTERCEPT_RESET;
    end else begin
      if (result.valid && result.ready) begin
        if (accept_q.size() == 0) begin
          $display("%0t: unexpected result transaction: expected none, actual accept %0b",
                   $time, result.accept);
          fail_count = fail_count + 1;
        end else begin
          head = accept_q.pop_front();
          if (result.accept !== head.accept) begin
            $display("%0t: accept mismatch: expected %0b, actual %0b (old %h new %h iter %0d draw %0d)",
                     $time, head.accept, result.accept, head.item.old_fitness,
                     head.item.new_fitness, head.item.iteration, head.item.random_draw);
            fail_count = fail_count + 1;
          end
        end
      end
      if (sample.valid && sample.ready) begin
        fresh.item.old_fitness = sample.old_fitness;
        fresh.item.new_fitness = sample.new_fitness;
        fresh.item.iteration   = sample.iteration;
        fresh.item.random_draw = sample.random_draw;
        fresh.accept           = predict_accept(fresh.item);
        accept_q.push_back(fresh);
      end
      // register writes land behind any test accepted at this edge
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_MODE:      cur_mode  <= cfg.data[1:0];
          REG_EXP_COEFF: cur_coeff <= cfg.data;
          REG_GRADIENT:  cur_grad  <= cfg.data;
          REG_INTERCEPT: cur_icpt  <= cfg.data[15:0];
          default: ;
        endcase
      end
      pending = accept_q.size();
    end
  end

endmodule

### test/annealing_acceptance_decision_tb.sv
`timescale 1ns / 1ps

module annealing_acceptance_decision_tb;
  import aad_pkg::*;

  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam int         HOLD_CYCLES = 60;
  localparam int         SRC_IDLE  [0:3] = '{0, 61, 0, 38};
  localparam int         SINK_STALL[0:3] = '{0, 0, 61, 38};
  localparam longint     FIT_MIN = -(64'sd1 <<< 31);
  localparam longint     FIT_MAX = (64'sd1 <<< 31) - 1;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   src_idle_pct   = 0;
  int   sink_stall_pct = 0;
  int   iter_span      = 24'hFFFFFF;
  bit   hold_req       = 1'b0;

  aad_in_if  sample_ch ();
  aad_out_if result_ch ();
  aad_cfg_if cfg_ch ();

  annealing_acceptance_decision u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  aad_decision_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample_ch),
    .result     (result_ch),
    .cfg        (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stalls, or a long hold-off on request
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Entered and left at a falling edge; valid stays high for a following test.
  task automatic push_sample(input logic [31:0] oldf, input logic [31:0] newf,
                             input logic [23:0] iter, input logic [15:0] draw);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.old_fitness <= oldf;
    sample_ch.new_fitness <= newf;
    sample_ch.iteration   <= iter;
    sample_ch.random_draw <= draw;
    do @(posedge clk); while (!sample_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // Drain the pipeline, then rewrite all four registers.
  task automatic apply_cfg(input logic [1:0] mode, input logic [31:0] coeff,
                           input logic [31:0] grad, input logic [15:0] icpt);
    sample_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    write_reg(REG_MODE, 32'(mode));
    write_reg(REG_EXP_COEFF, coeff);
    write_reg(REG_GRADIENT, grad);
    write_reg(REG_INTERCEPT, 32'(icpt));
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly worse candidates by a spread of margins, some improvements, some noise.
  task automatic send_random_batch(input int count);
    int          i, kind, sh;
    longint      o, n, dlt;
    logic [23:0] it;
    for (i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      o    = longint'($signed($urandom));
      sh   = $urandom_range(24);
      dlt  = longint'($urandom_range(1 << sh));
      if (kind < 10) begin
        n = longint'($signed($urandom));
      end else if (kind < 25) begin
        n = o + dlt + 1;
        if (n > FIT_MAX) begin
          n = FIT_MAX;
          o = n - dlt - 1;
        end
      end else begin
        n = o - dlt;
        if (n < FIT_MIN) begin
          n = FIT_MIN;
          o = n + dlt;
        end
      end
      it = ($urandom_range(99) < 80) ? 24'($urandom_range(iter_span)) : 24'($urandom);
      push_sample(32'(o), 32'(n), it, 16'($urandom));
    end
  endtask

  initial begin
    int          ph, c, maxit;
    logic [1:0]  m;
    logic [31:0] co, gr;
    logic [15:0] ic;

    rst                   = 1'b1;
    sample_ch.valid       = 1'b0;
    sample_ch.old_fitness = '0;
    sample_ch.new_fitness = '0;
    sample_ch.iteration   = '0;
    sample_ch.random_draw = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = REG_MODE;
    cfg_ch.data           = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // improvements only, straight out of reset
    push_sample(32'h0000_0000, 32'h0001_0000, 24'd0, 16'hFFFF);
    push_sample(32'h7FFF_FFFF, 32'h8000_0000, 24'hFFFFFF, 16'h0000);
    push_sample(32'h1234_5678, 32'h1234_5678, 24'd0, 16'h0000);

    // unused mode code behaves like improvements only
    apply_cfg(MODE_SPARE, 32'h0, 32'h0, INTERCEPT_RESET);
    push_sample(32'd100, 32'd50, 24'd5, 16'h0000);
    push_sample(32'd50, 32'd100, 24'd5, 16'h0000);

    // positive decay coefficient: always accept
    apply_cfg(MODE_EXP, 32'h7FFF_FFFF, 32'h0, INTERCEPT_RESET);
    push_sample(32'h0001_0000, 32'h0, 24'hFFFFFF, 16'hFFFF);

    // most negative coefficient: zero iteration, saturated exponent, equal fitness
    apply_cfg(MODE_EXP, 32'h8000_0000, 32'h8000_0000, 16'h0000);
    push_sample(32'h0000_0100, 32'h0000_0100, 24'd0, 16'hFFFF);
    push_sample(32'h0000_0001, 32'h0, 24'hFFFFFF, 16'h0000);
    push_sample(32'h7FFF_FFFF, 32'h8000_0000, 24'hFFFFFF, 16'h0000);
    push_sample(32'hFFFF_0000, 32'hFFFF_0000, 24'hFFFFFF, 16'hFFFF);

    // full intercept, flat gradient: probability just under one
    apply_cfg(MODE_LIN, 32'h0, 32'h0, 16'hFFFF);
    push_sample(32'h0, 32'h0, 24'd0, 16'hFFFE);
    push_sample(32'h0, 32'h0, 24'd0, 16'hFFFF);
    push_sample(32'd7, 32'd7, 24'hFFFFFF, 16'h0000);

    // negative decay clamps to zero
    apply_cfg(MODE_LIN, 32'h0, 32'h8000_0000, 16'h0000);
    push_sample(32'h0, 32'h0, 24'd1, 16'h0000);

    // huge decay clamps at the top, saturated exponent still rejects
    apply_cfg(MODE_LIN, 32'h0, 32'h7FFF_FFFF, 16'hFFFF);
    push_sample(32'h0001_0000, 32'h0, 24'hFFFFFF, 16'hFFFF);
    push_sample(32'h7FFF_FFFF, 32'h8000_0000, 24'hFFFFFF, 16'h0000);

    // a typical schedule
    apply_cfg(MODE_EXP, 32'(-29074), 32'h0, INTERCEPT_RESET);
    push_sample(32'h0002_0000, 32'h0, 24'd1000, 16'h4000);
    push_sample(32'h0000_0800, 32'h0, 24'd500, 16'h8000);

    for (ph = 0; ph < 4; ph++) begin
      src_idle_pct   = SRC_IDLE[ph];
      sink_stall_pct = SINK_STALL[ph];
      for (c = 0; c < 3; c++) begin
        maxit     = $urandom_range(1 << 20, 10);
        iter_span = maxit;
        case (c)
          0: begin
            m  = MODE_EXP;
            co = 32'(-int'(0.6931471805599453 * 2.5 * 16777216.0 / real'(maxit)));
            gr = $urandom;
            ic = 16'($urandom);
          end
          1: begin
            m  = MODE_LIN;
            co = $urandom;
            gr = 32'(-int'(0.5 * 16777216.0 / real'(maxit)));
            ic = $urandom_range(1) ? INTERCEPT_RESET : 16'($urandom);
          end
          default: begin
            iter_span = 24'hFFFFFF;
            if (ph == 1) begin
              m  = MODE_EXP;
              co = 32'h8000_0000;
              gr = 32'h8000_0000;
              ic = 16'h0000;
            end else if (ph == 3) begin
              m  = MODE_LIN;
              co = 32'h0;
              gr = 32'h0;
              ic = 16'hFFFF;
            end else begin
              m  = 2'($urandom_range(3));
              co = $urandom;
              gr = $urandom;
              ic = 16'($urandom);
            end
          end
        endcase
        apply_cfg(m, co, gr, ic);
        send_random_batch(75);
        if (ph == 0 && c == 0) begin
          // hold off the result side and keep offering until the input backs up
          hold_req = 1'b1;
          send_random_batch(30);
        end
      end
    end

    sample_ch.valid <= 1'b0;
    for (c = 0; c < 5000 && pending != 0; c++) @(negedge clk);
    repeat (20) @(negedge clk);
    if (pending != 0)
      $display("%0t: %0d decisions never returned", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
